FILE: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the Go-Back-N sender core.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int MSG_WORDS = 5;

    // Ring store depth; a power of two, so a slot is the low bits of a seqnum
    localparam int STORE_SLOTS = 64;

    localparam logic [1:0] OP_MESSAGE = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic KIND_SENT    = 1'b0;
    localparam logic KIND_DROPPED = 1'b1;

    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [5:0]  WINDOW_RESET  = 6'd8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd16;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        word0;
        logic [31:0]        word1;
        logic [31:0]        word2;
        logic [31:0]        word3;
        logic [31:0]        word4;
        logic signed [31:0] ack_seq;
        logic signed [31:0] ack_number;
        logic signed [31:0] ack_check;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [31:0]        out_seq;
        logic signed [31:0] out_check;
        logic [31:0]        out_word0;
        logic [31:0]        out_word1;
        logic [31:0]        out_word2;
        logic [31:0]        out_word3;
        logic [31:0]        out_word4;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_EMIT,
        ST_WAIT
    } state_t;

    // Signed byte sum of one 32-bit word
    function automatic logic [31:0] word_sum(input logic [31:0] w);
        logic [31:0] s;
        s = 32'd0;
        for (int b = 0; b < 4; b++) begin
            s = s + {{24{w[8*b+7]}}, w[8*b +: 8]};
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/go_back_n_sender_core.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_core
// Go-Back-N ARQ sender with a ring store of messages in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one transaction: a new message, an arriving ack or a
//   timer tick. m_ channel gives the results: sent packets (kind 0) or a
//   drop flag (kind 1) when the store is full; last marks the final result
//   of an input. Inputs with no result (bad ack, tick before expiry, unused
//   code) free the input again once the decide and wait states are passed.
//   Configuration: cfg_we, cfg_index, cfg_data; the user must write them only when idle, the block does not enforce it.
// Sequencing:
//   An item is decided in the cycle after acceptance. A drop flag is registered
//   in the decide state; the first packet goes through the wait, read and emit
//   states, each further packet through wait, read and emit again when the
//   receiver is ready; the sequencing state machine sets the pace.
// Reset:
//   aresetn clears window base, counters and timer; registers take their
//   defaults (window 8, timeout 16). The memory needs no clearing.
// Stall:
//   While m_ready is low the result is held and no new transaction is taken.
// ----------------------------------------------------------------------------
module go_back_n_sender_core #(
    parameter int MAX_WINDOW  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gbn_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gbn_pkg::out_item_t  m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import gbn_pkg::*;

    localparam int SLOT_W = $clog2(STORE_SLOTS);

    logic [5:0]   window_reg;
    logic [15:0]  timeout_reg;
    logic [31:0]  base_reg, base_next;
    logic [31:0]  nts_reg, nts_next;
    logic [31:0]  end_reg, end_next;
    logic         trun_reg, trun_next;
    logic [15:0]  tleft_reg, tleft_next;
    logic         send_reg, send_next;
    state_t       state_reg, state_next;
    in_item_t     item_reg;
    logic [31:0]  acksum_reg;
    out_item_t    out_reg, out_next;
    logic         ovalid_reg, ovalid_next;

    logic [32*MSG_WORDS-1:0] mem [STORE_SLOTS];
    logic [32*MSG_WORDS-1:0] rd_reg;
    logic                    mem_we;
    logic [32*MSG_WORDS-1:0] wr_data;

    logic [31:0] win_eff;
    logic [15:0] tout_eff;
    logic        can_send;
    logic [31:0] pkt_sum;
    logic        more;

    // Clamp the configured window and timeout
    always_comb begin
        if (window_reg == 6'd0) begin
            win_eff = 32'd1;
        end else if (32'(window_reg) > 32'(MAX_WINDOW)) begin
            win_eff = 32'(MAX_WINDOW);
        end else begin
            win_eff = 32'(window_reg);
        end
        tout_eff = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    end

    assign can_send = ((nts_reg - base_reg) < (end_reg - base_reg)) &&
                      ((nts_reg - base_reg) < win_eff);

    // Truncate message bytes after the first zero byte
    always_comb begin
        logic ended;
        logic [159:0] raw;
        ended = 1'b0;
        raw = {item_reg.word4, item_reg.word3, item_reg.word2,
               item_reg.word1, item_reg.word0};
        wr_data = '0;
        for (int i = 0; i < 20; i++) begin
            if (raw[8*i +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                wr_data[8*i +: 8] = raw[8*i +: 8];
            end
        end
    end

    always_comb begin
        pkt_sum = 32'd0;
        for (int i = 0; i < MSG_WORDS; i++) begin
            pkt_sum = pkt_sum + word_sum(rd_reg[32*i +: 32]);
        end
    end

    // Memory: write on message store, read the packet to send
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[end_reg[SLOT_W-1:0]] <= wr_data;
        end
        rd_reg <= mem[nts_reg[SLOT_W-1:0]];
    end

    assign s_ready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid && s_ready) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_WAIT;
            ST_READ:   state_next = ST_EMIT;
            ST_EMIT:   state_next = ST_WAIT;
            ST_WAIT: begin
                if (!ovalid_reg || m_ready) begin
                    state_next = more ? ST_READ : ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        base_next   = base_reg;
        nts_next    = nts_reg;
        end_next    = end_reg;
        trun_next   = trun_reg;
        tleft_next  = tleft_reg;
        send_next   = send_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        mem_we      = 1'b0;
        // Send only for a stored message, an accepted ack or an expiry
        more        = can_send && send_reg;
        if (ovalid_reg && m_ready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_DECIDE: begin
                more      = 1'b0;
                send_next = 1'b0;
                case (item_reg.operation)
                    OP_MESSAGE: begin
                        if ((end_reg - base_reg) >= 32'(STORE_SLOTS)) begin
                            out_next      = '0;
                            out_next.kind = KIND_DROPPED;
                            out_next.last = 1'b1;
                            ovalid_next   = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            end_next  = end_reg + 32'd1;
                            send_next = 1'b1;
                        end
                    end
                    OP_ACK: begin
                        if (acksum_reg == item_reg.ack_check &&
                            (item_reg.ack_number - base_reg) < (nts_reg - base_reg)) begin
                            base_next = item_reg.ack_number + 32'd1;
                            send_next = 1'b1;
                            if (base_next == nts_reg) begin
                                trun_next = 1'b0;
                            end else begin
                                trun_next  = 1'b1;
                                tleft_next = tout_eff;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (trun_reg) begin
                            if (tleft_reg <= 16'd1) begin
                                trun_next  = 1'b0;
                                tleft_next = 16'd0;
                                nts_next   = base_reg;
                                send_next  = 1'b1;
                            end else begin
                                tleft_next = tleft_reg - 16'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_EMIT: begin
                out_next.kind      = KIND_SENT;
                out_next.out_seq   = nts_reg;
                out_next.out_check = nts_reg + pkt_sum;
                out_next.out_word0 = rd_reg[31:0];
                out_next.out_word1 = rd_reg[63:32];
                out_next.out_word2 = rd_reg[95:64];
                out_next.out_word3 = rd_reg[127:96];
                out_next.out_word4 = rd_reg[159:128];
                ovalid_next        = 1'b1;
                if (nts_reg == base_reg) begin
                    trun_next  = 1'b1;
                    tleft_next = tout_eff;
                end
                nts_next = nts_reg + 32'd1;
                // Last when nothing further can go out after this one
                out_next.last = !(((nts_next - base_reg) < (end_reg - base_reg)) &&
                                  ((nts_next - base_reg) < win_eff));
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RESET;
            timeout_reg <= TIMEOUT_RESET;
            base_reg    <= '0;
            nts_reg     <= '0;
            end_reg     <= '0;
            trun_reg    <= 1'b0;
            tleft_reg   <= '0;
            send_reg    <= 1'b0;
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_WINDOW) begin
                    window_reg <= cfg_data[5:0];
                end else begin
                    timeout_reg <= cfg_data;
                end
            end
            base_reg   <= base_next;
            nts_reg    <= nts_next;
            end_reg    <= end_next;
            trun_reg   <= trun_next;
            tleft_reg  <= tleft_next;
            send_reg   <= send_next;
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Capture the transaction and its ack checksum
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_valid && s_ready) begin
            item_reg   <= s_data;
            acksum_reg <= s_data.ack_seq + s_data.ack_number +
                          word_sum(s_data.word0) + word_sum(s_data.word1) +
                          word_sum(s_data.word2) + word_sum(s_data.word3) +
                          word_sum(s_data.word4);
        end
    end

endmodule
